// ===== src/tsnb_pkg.sv =====
// ----------------------------------------------------------------------------
// Texture sampler package
// Shared constants and types for the nearest/bilinear texture sampler.
// ----------------------------------------------------------------------------
package tsnb_pkg;

  localparam int unsigned MaxWidth    = 256;
  localparam int unsigned MaxHeight   = 256;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned Depth       = MaxWidth * MaxHeight;
  localparam int unsigned AddrW       = $clog2(Depth);
  localparam int unsigned XW          = $clog2(MaxWidth);
  localparam int unsigned YW          = $clog2(MaxHeight);
  localparam int unsigned CoordW      = FracBits + 2;
  localparam int unsigned ClampW      = FracBits + 1;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegFilter = 2'd2;

  localparam logic ReqWrite  = 1'b0;
  localparam logic ReqSample = 1'b1;

  localparam logic ModeNearest  = 1'b0;
  localparam logic ModeBilinear = 1'b1;

  // Clamp a signed coordinate to 0..one.
  function automatic logic [ClampW-1:0] clamp_coord(input logic signed [CoordW-1:0] c);
    logic [ClampW-1:0] r;
    if (c[CoordW-1]) begin
      r = '0;
    end else if (c[CoordW-2]) begin
      r = ClampW'(1) << FracBits;
    end else begin
      r = c[ClampW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/texture_sampler_nearest_bilinear_top.sv =====
// ----------------------------------------------------------------------------
// Texture sampler, nearest and bilinear
// A sample word passes through stages 1 to 5; stage 5 drives the result strobe.
// Throughput: one word per cycle; the four texel reads use four copies of
// the texel store, so every sample reads all its texels in the same cycle.
// A write word passes registers wr1 and wr2 to the store, in step with the
// read stage, so every sample sees exactly the writes taken before it.
// Reset clears the valid bits and the registers (256, 256, nearest); the
// texel store is undefined until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module texture_sampler_nearest_bilinear_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        req_type_i,
  input  logic [15:0] texel_index_i,
  input  logic [31:0] texel_value_i,
  input  logic signed [17:0] u_coord_i,
  input  logic signed [17:0] v_coord_i,
  output logic        strobe_o,
  output logic [15:0] red_o,
  output logic [15:0] green_o,
  output logic [15:0] blue_o,
  output logic [15:0] alpha_o
);

  localparam int unsigned AW = tsnb_pkg::AddrW;
  localparam int unsigned XW = tsnb_pkg::XW;
  localparam int unsigned YW = tsnb_pkg::YW;
  localparam int unsigned FB = tsnb_pkg::FracBits;
  localparam int unsigned CW = tsnb_pkg::ClampW;

  // The pipeline never stalls, so a word can be accepted every cycle.
  assign busy_o = 1'b0;

  logic       accept;
  assign accept = start_i & ~busy_o;

  // Configuration registers.
  logic [8:0] width_q, height_q;
  logic       mode_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      mode_q   <= tsnb_pkg::ModeNearest;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tsnb_pkg::RegWidth:  width_q  <= cfg_data_i;
        tsnb_pkg::RegHeight: height_q <= cfg_data_i;
        tsnb_pkg::RegFilter: mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective sizes minus one: zero acts as one, oversize saturates.
  logic [XW-1:0] wm1;
  logic [YW-1:0] hm1;
  always_comb begin
    if (width_q == 9'd0) wm1 = '0;
    else if (width_q > 9'(tsnb_pkg::MaxWidth)) wm1 = XW'(tsnb_pkg::MaxWidth - 1);
    else wm1 = XW'(width_q - 9'd1);
    if (height_q == 9'd0) hm1 = '0;
    else if (height_q > 9'(tsnb_pkg::MaxHeight)) hm1 = YW'(tsnb_pkg::MaxHeight - 1);
    else hm1 = YW'(height_q - 9'd1);
  end

  // Stage 1: clamp, flip v, scale by size minus one.
  logic          s1_v_q;
  logic [CW+XW-1:0] px_q;
  logic [CW+YW-1:0] py_q;
  logic [CW-1:0] uc, vc;
  always_comb begin
    uc = tsnb_pkg::clamp_coord(u_coord_i);
    vc = (CW'(1) << FB) - tsnb_pkg::clamp_coord(v_coord_i);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else         s1_v_q <= accept & (req_type_i == tsnb_pkg::ReqSample);
  end
  always_ff @(posedge clk_i) begin
    px_q <= (CW+XW)'(uc) * (CW+XW)'(wm1);
    py_q <= (CW+YW)'(vc) * (CW+YW)'(hm1);
  end

  // Stage 2: texel, neighbour, weights, addresses.
  logic [XW-1:0] i_c, xn_c;
  logic [YW-1:0] j_c, yn_c;
  logic [FB-1:0] fx, fy;
  logic [8:0]    wx_c, wy_c;
  logic [AW-1:0] a00_q, a10_q, a01_q, a11_q;
  logic [8:0]    wx_q, wy_q;
  logic          s2_v_q;
  localparam logic [FB-1:0] Half = FB'(1) << (FB - 1);
  always_comb begin
    i_c = px_q[FB +: XW];
    j_c = py_q[FB +: YW];
    fx  = px_q[FB-1:0];
    fy  = py_q[FB-1:0];
    if (fx < Half) begin
      wx_c = 9'((Half - fx) >> (FB - 8));
      xn_c = (i_c == '0) ? '0 : i_c - XW'(1);
    end else begin
      wx_c = 9'((fx - Half) >> (FB - 8));
      xn_c = (i_c >= wm1) ? wm1 : i_c + XW'(1);
    end
    if (fy < Half) begin
      wy_c = 9'((Half - fy) >> (FB - 8));
      yn_c = (j_c == '0) ? '0 : j_c - YW'(1);
    end else begin
      wy_c = 9'((fy - Half) >> (FB - 8));
      yn_c = (j_c >= hm1) ? hm1 : j_c + YW'(1);
    end
    // Nearest mode is a bilinear blend with zero weights, and all four reads
    // land on the one texel so no neighbour is ever touched.
    if (mode_q == tsnb_pkg::ModeNearest) begin
      wx_c = '0;
      wy_c = '0;
      xn_c = i_c;
      yn_c = j_c;
    end
  end
  // Row-major address: y*(wm1+1)+x, which stays below the depth.
  function automatic logic [AW-1:0] addr(input logic [YW-1:0] y, input logic [XW-1:0] x,
                                         input logic [XW-1:0] w1);
    return AW'(AW'(y) * (AW'(w1) + AW'(1)) + AW'(x));
  endfunction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else         s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    a00_q <= addr(j_c, i_c, wm1);
    a10_q <= addr(j_c, xn_c, wm1);
    a01_q <= addr(yn_c, i_c, wm1);
    a11_q <= addr(yn_c, xn_c, wm1);
    wx_q  <= wx_c;
    wy_q  <= wy_c;
  end

  // Write words travel two stages so they reach the store in the cycle
  // that matches the read stage of the sample words around them.
  logic          wr1_q, wr2_q;
  logic [AW-1:0] widx1_q, widx2_q;
  logic [31:0]   wval1_q, wval2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr1_q <= 1'b0;
      wr2_q <= 1'b0;
    end else begin
      wr1_q <= accept & (req_type_i == tsnb_pkg::ReqWrite);
      wr2_q <= wr1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    widx1_q <= texel_index_i[AW-1:0];
    wval1_q <= texel_value_i;
    widx2_q <= widx1_q;
    wval2_q <= wval1_q;
  end

  // Four copies of the texel store, all written by every write word.
  logic [31:0] mem00 [tsnb_pkg::Depth];
  logic [31:0] mem10 [tsnb_pkg::Depth];
  logic [31:0] mem01 [tsnb_pkg::Depth];
  logic [31:0] mem11 [tsnb_pkg::Depth];
  always_ff @(posedge clk_i) begin
    if (wr2_q) begin
      mem00[widx2_q] <= wval2_q;
      mem10[widx2_q] <= wval2_q;
      mem01[widx2_q] <= wval2_q;
      mem11[widx2_q] <= wval2_q;
    end
  end

  // Stage 3: registered reads.
  logic [31:0] t00_q, t10_q, t01_q, t11_q;
  logic [8:0]  wx3_q, wy3_q;
  logic        s3_v_q;
  always_ff @(posedge clk_i) begin
    t00_q <= mem00[a00_q];
    t10_q <= mem10[a10_q];
    t01_q <= mem01[a01_q];
    t11_q <= mem11[a11_q];
    wx3_q <= wx_q;
    wy3_q <= wy_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else         s3_v_q <= s2_v_q;
  end

  // Stage 4: row blends, exact in 8.8.
  logic [15:0] r0_q [4];
  logic [15:0] r1_q [4];
  logic [8:0]  wy4_q;
  logic        s4_v_q;
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      r0_q[k] <= 16'(17'(9'd256 - wx3_q) * 17'(t00_q[8*k +: 8]) +
                     17'(wx3_q) * 17'(t10_q[8*k +: 8]));
      r1_q[k] <= 16'(17'(9'd256 - wx3_q) * 17'(t01_q[8*k +: 8]) +
                     17'(wx3_q) * 17'(t11_q[8*k +: 8]));
    end
    wy4_q <= wy3_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else         s4_v_q <= s3_v_q;
  end

  // Stage 5: column blend, truncated to 8.8, into the output register.
  logic [15:0] out_q [4];
  logic        s5_v_q;
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      out_q[k] <= 16'(((25'(9'd256 - wy4_q) * 25'(r0_q[k])) + (25'(wy4_q) * 25'(r1_q[k]))) >> 8);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else         s5_v_q <= s4_v_q;
  end

  assign strobe_o = s5_v_q;
  assign red_o    = out_q[0];
  assign green_o  = out_q[1];
  assign blue_o   = out_q[2];
  assign alpha_o  = out_q[3];

endmodule

// ===== src/tsnb_checker.sv =====
// ----------------------------------------------------------------------------
// Texture sampler port checker
// Checks latency, no write results, ranges and low busy on the top's ports.
// ----------------------------------------------------------------------------
module tsnb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        req_type_i,
  input logic        strobe_o,
  input logic [15:0] red_o,
  input logic [15:0] alpha_o
);

  logic samp;
  assign samp = start_i & ~busy_o & req_type_i;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    samp |-> ##5 strobe_o) else $error("sample result missing");

  a_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !req_type_i) |-> ##5 !strobe_o) else $error("write gave a result");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (red_o <= 16'hFF00 && alpha_o <= 16'hFF00)) else $error("result out of range");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");

endmodule

bind texture_sampler_nearest_bilinear_top tsnb_checker u_tsnb_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .req_type_i(req_type_i), .strobe_o(strobe_o), .red_o(red_o), .alpha_o(alpha_o)
);

// ===== bench/texture_sampler_nearest_bilinear_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Texture sampler testbench
// Drives texel writes and sample words into the sampler under random idle
// gaps and several texture sizes and filter modes. Each accepted sample's
// expected result is typed in or predicted from a local copy of the texel
// store, and is checked field by field against the strobed result.
// ----------------------------------------------------------------------------
module texture_sampler_nearest_bilinear_top_tb;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int unsigned CoordOne = 1 << tsnb_pkg::FracBits;
  localparam int unsigned CoordHalf = 1 << (tsnb_pkg::FracBits - 1);
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumPhases = 12;
  localparam int unsigned WordsPerPhase = 80;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } rgba_t;

  // One row of the directed stimulus. Where has_fixed is set, the typed
  // result is the one expected; otherwise the predictor supplies it.
  typedef struct packed {
    logic               req;
    logic [15:0]        index;
    logic [31:0]        value;
    logic signed [17:0] u;
    logic signed [17:0] v;
    logic               has_fixed;
    rgba_t              fixed;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = tsnb_pkg::RegWidth;
  logic [8:0]         cfg_data_i = '0;
  logic               req_type_i = tsnb_pkg::ReqWrite;
  logic [15:0]        texel_index_i = '0;
  logic [31:0]        texel_value_i = '0;
  logic signed [17:0] u_coord_i = '0;
  logic signed [17:0] v_coord_i = '0;
  logic               strobe_o;
  logic [15:0]        red_o;
  logic [15:0]        green_o;
  logic [15:0]        blue_o;
  logic [15:0]        alpha_o;

  texture_sampler_nearest_bilinear_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_type_i   (req_type_i),
    .texel_index_i(texel_index_i),
    .texel_value_i(texel_value_i),
    .u_coord_i    (u_coord_i),
    .v_coord_i    (v_coord_i),
    .strobe_o     (strobe_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Local copy of the sampler state. The written flags are set when a write
  // is scheduled, so that no sample is ever sent that reads a texel which
  // has not been filled first.
  logic [31:0] texel_copy [tsnb_pkg::Depth];
  bit          texel_written [tsnb_pkg::Depth];
  logic [8:0]  width_reg = 9'd256;
  logic [8:0]  height_reg = 9'd256;
  logic        mode_reg = tsnb_pkg::ModeNearest;

  rgba_t       pending_samples [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_enable;

  // Directed words, all under the reset configuration (256 x 256, nearest).
  // The corner texels are written first so their samples can be read off
  // directly; v is flipped, so v = 1 lands on row zero.
  dir_row_t dir_rows [12] = '{
    '{tsnb_pkg::ReqWrite,  16'd0,     32'h04030201, 18'sd0, 18'sd0, 1'b0, rgba_t'(0)},
    '{tsnb_pkg::ReqWrite,  16'd65535, 32'hFFFFFFFF, 18'sd0, 18'sd0, 1'b0, rgba_t'(0)},
    '{tsnb_pkg::ReqWrite,  16'd255,   32'h00000000, -18'sd1, 18'sd131071, 1'b0, rgba_t'(0)},
    '{tsnb_pkg::ReqWrite,  16'd65280, 32'hA55A3CC3, -18'sd131072, -18'sd1, 1'b0,
      rgba_t'(0)},
    '{tsnb_pkg::ReqSample, 16'hFFFF,  32'hFFFFFFFF, 18'sd0, 18'sd65536, 1'b1,
      rgba_t'({16'h0100, 16'h0200, 16'h0300, 16'h0400})},
    '{tsnb_pkg::ReqSample, 16'h0000,  32'h00000000, -18'sd131072, 18'sd131071, 1'b1,
      rgba_t'({16'h0100, 16'h0200, 16'h0300, 16'h0400})},
    '{tsnb_pkg::ReqSample, 16'h1234,  32'h0, 18'sd65536, 18'sd0, 1'b1,
      rgba_t'({16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00})},
    '{tsnb_pkg::ReqSample, 16'h0,     32'h0, 18'sd131071, -18'sd1, 1'b1,
      rgba_t'({16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00})},
    '{tsnb_pkg::ReqSample, 16'h0,     32'h0, 18'sd65536, 18'sd65536, 1'b1, rgba_t'(0)},
    '{tsnb_pkg::ReqSample, 16'h0,     32'h0, 18'sd0, 18'sd0, 1'b1,
      rgba_t'({16'hC300, 16'h3C00, 16'h5A00, 16'hA500})},
    '{tsnb_pkg::ReqSample, 16'h0,     32'h0, 18'sd32768, 18'sd32768, 1'b0, rgba_t'(0)},
    '{tsnb_pkg::ReqSample, 16'h0,     32'h0, 18'sd32767, 18'sd257, 1'b0, rgba_t'(0)}
  };

  function automatic int unsigned eff_size(logic [8:0] reg_val, int unsigned max_val);
    if (reg_val == 0) return 1;
    return (reg_val > max_val) ? max_val : reg_val;
  endfunction

  function automatic int unsigned clamp_unit(logic signed [17:0] c);
    if (c < 0) return 0;
    if (int'(c) > int'(CoordOne)) return CoordOne;
    return int'(c);
  endfunction

  // Works out the four texel addresses and the two blend weights of a
  // sample. Nearest mode is the bilinear blend with both weights zero and
  // all four addresses on the same texel, which gives exactly value << 8.
  function automatic void locate_texels(input logic signed [17:0] u,
                                        input logic signed [17:0] v,
                                        output int unsigned addr [4],
                                        output int unsigned wx,
                                        output int unsigned wy);
    int unsigned w, h, px, py, i, j, fx, fy, xn, yn;
    w  = eff_size(width_reg, tsnb_pkg::MaxWidth);
    h  = eff_size(height_reg, tsnb_pkg::MaxHeight);
    px = clamp_unit(u) * (w - 1);
    py = (CoordOne - clamp_unit(v)) * (h - 1);
    i  = px >> tsnb_pkg::FracBits;
    j  = py >> tsnb_pkg::FracBits;
    fx = px & (CoordOne - 1);
    fy = py & (CoordOne - 1);
    if (mode_reg == tsnb_pkg::ModeNearest) begin
      xn = i;
      yn = j;
      wx = 0;
      wy = 0;
    end else begin
      // The neighbour sits on the side the fraction leans toward; exactly
      // one half counts as leaning right or down.
      if (fx < CoordHalf) begin
        fx = CoordHalf - fx;
        xn = (i == 0) ? 0 : i - 1;
      end else begin
        fx = fx - CoordHalf;
        xn = (i + 1 > w - 1) ? w - 1 : i + 1;
      end
      if (fy < CoordHalf) begin
        fy = CoordHalf - fy;
        yn = (j == 0) ? 0 : j - 1;
      end else begin
        fy = fy - CoordHalf;
        yn = (j + 1 > h - 1) ? h - 1 : j + 1;
      end
      wx = fx >> (tsnb_pkg::FracBits - 8);
      wy = fy >> (tsnb_pkg::FracBits - 8);
    end
    addr[0] = j * w + i;
    addr[1] = j * w + xn;
    addr[2] = yn * w + i;
    addr[3] = yn * w + xn;
  endfunction

  function automatic rgba_t blend_texels(int unsigned addr [4], int unsigned wx,
                                         int unsigned wy);
    rgba_t       res;
    int unsigned r0, r1;
    logic [15:0] ch [4];
    for (int k = 0; k < 4; k++) begin
      r0 = (256 - wx) * texel_copy[addr[0]][8*k +: 8] + wx * texel_copy[addr[1]][8*k +: 8];
      r1 = (256 - wx) * texel_copy[addr[2]][8*k +: 8] + wx * texel_copy[addr[3]][8*k +: 8];
      ch[k] = 16'(((256 - wy) * r0 + wy * r1) >> 8);
    end
    res.red   = ch[0];
    res.green = ch[1];
    res.blue  = ch[2];
    res.alpha = ch[3];
    return res;
  endfunction

  // Presents one word and holds it until the sampler takes it. Start stays
  // high on return; the caller lowers it only when a gap follows.
  task automatic send_word(logic req, logic [15:0] index, logic [31:0] value,
                           logic signed [17:0] u, logic signed [17:0] v,
                           bit has_fixed, rgba_t fixed);
    int unsigned addr [4];
    int unsigned wx, wy;
    start_i       <= 1'b1;
    req_type_i    <= req;
    texel_index_i <= index;
    texel_value_i <= value;
    u_coord_i     <= u;
    v_coord_i     <= v;
    do @(posedge clk_i); while (busy_o);
    if (req == tsnb_pkg::ReqWrite) begin
      texel_copy[index] = value;
    end else begin
      locate_texels(u, v, addr, wx, wy);
      pending_samples.push_back(has_fixed ? fixed : blend_texels(addr, wx, wy));
    end
  endtask

  task automatic idle_gap();
    int unsigned r, n;
    r = $urandom_range(0, 99);
    n = (!idle_enable || r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic write_texel(logic [15:0] index, logic [31:0] value);
    texel_written[index] = 1'b1;
    send_word(tsnb_pkg::ReqWrite, index, value, 18'($urandom), 18'($urandom), 1'b0,
              rgba_t'(0));
    idle_gap();
  endtask

  // Fills any texel the sample would read that holds nothing yet, then
  // sends the sample itself with junk in the write fields.
  task automatic sample_at(logic signed [17:0] u, logic signed [17:0] v, bit has_fixed,
                           rgba_t fixed);
    int unsigned addr [4];
    int unsigned wx, wy;
    locate_texels(u, v, addr, wx, wy);
    for (int k = 0; k < 4; k++) begin
      if (!texel_written[addr[k]]) write_texel(16'(addr[k]), $urandom);
    end
    send_word(tsnb_pkg::ReqSample, 16'($urandom), $urandom, u, v, has_fixed, fixed);
    idle_gap();
  endtask

  task automatic drain_samples();
    start_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the sampler idle. Writes leave nothing to
  // wait for, so a wait that outlasts the pipeline is added after the drain.
  task automatic set_register(logic [1:0] index, logic [8:0] data);
    drain_samples();
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      tsnb_pkg::RegWidth:  width_reg = data;
      tsnb_pkg::RegHeight: height_reg = data;
      tsnb_pkg::RegFilter: mode_reg = data[0];
      default: ;
    endcase
  endtask

  // Coordinate mix: raw 18-bit noise, the clamp edges, texel centers with a
  // little jitter (the bilinear half-way split), and plain in-range values.
  function automatic logic signed [17:0] pick_coord(int unsigned size);
    int unsigned r, k;
    int          c;
    r = $urandom_range(0, 9);
    if (r < 2) return 18'($urandom);
    if (r == 2) begin
      case ($urandom_range(0, 3))
        0: return 18'sd0;
        1: return 18'sd65536;
        2: return -18'sd1;
        default: return 18'sd65537;
      endcase
    end
    if (r < 6 && size > 1) begin
      k = $urandom_range(0, size - 1);
      c = (int'(k << tsnb_pkg::FracBits) + int'(CoordHalf) +
           int'($urandom_range(0, 600)) - 300) / int'(size - 1);
      if (c < 0) c = 0;
      if (c > int'(CoordOne)) c = CoordOne;
      return 18'(c);
    end
    return 18'($urandom_range(0, CoordOne));
  endfunction

  // Checks each strobed result against the oldest pending expectation.
  always @(posedge clk_i) begin
    rgba_t exp_px;
    if (rst_ni && strobe_o) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: result with no sample pending: %h %h %h %h", $time,
                 red_o, green_o, blue_o, alpha_o);
        error_count++;
      end else begin
        exp_px = pending_samples.pop_front();
        if (red_o !== exp_px.red) begin
          $display("%0t: red expected %h actual %h", $time, exp_px.red, red_o);
          error_count++;
        end
        if (green_o !== exp_px.green) begin
          $display("%0t: green expected %h actual %h", $time, exp_px.green, green_o);
          error_count++;
        end
        if (blue_o !== exp_px.blue) begin
          $display("%0t: blue expected %h actual %h", $time, exp_px.blue, blue_o);
          error_count++;
        end
        if (alpha_o !== exp_px.alpha) begin
          $display("%0t: alpha expected %h actual %h", $time, exp_px.alpha, alpha_o);
          error_count++;
        end
      end
    end
  end

  // A hung sampler ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Phase settings: width, height, mode. Zero sizes act as one and sizes
  // above the maximum act as the maximum; most of the rest are small so that
  // the random part revisits the same texels often.
  logic [8:0] phase_w [NumPhases] = '{9'd4, 9'd1, 9'd0, 9'd511, 9'd256, 9'd3,
                                      9'd2, 9'd17, 9'd256, 9'd1, 9'd5, 9'd8};
  logic [8:0] phase_h [NumPhases] = '{9'd4, 9'd1, 9'd0, 9'd300, 9'd256, 9'd7,
                                      9'd1, 9'd5, 9'd1, 9'd256, 9'd5, 9'd3};
  logic       phase_m [NumPhases] = '{tsnb_pkg::ModeBilinear, tsnb_pkg::ModeBilinear,
                                      tsnb_pkg::ModeNearest, tsnb_pkg::ModeBilinear,
                                      tsnb_pkg::ModeBilinear, tsnb_pkg::ModeNearest,
                                      tsnb_pkg::ModeBilinear, tsnb_pkg::ModeBilinear,
                                      tsnb_pkg::ModeBilinear, tsnb_pkg::ModeNearest,
                                      tsnb_pkg::ModeBilinear, tsnb_pkg::ModeBilinear};

  initial begin
    int unsigned w, h, n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_enable = 1'b1;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].req == tsnb_pkg::ReqWrite) begin
        write_texel(dir_rows[r].index, dir_rows[r].value);
      end else begin
        sample_at(dir_rows[r].u, dir_rows[r].v, dir_rows[r].has_fixed, dir_rows[r].fixed);
      end
    end
    // The unused index must leave the width alone.
    set_register(RegUnused, 9'd1);
    sample_at(18'sd65536, 18'sd0, 1'b0, rgba_t'(0));

    for (int p = 0; p < NumPhases; p++) begin
      set_register(tsnb_pkg::RegWidth, phase_w[p]);
      set_register(tsnb_pkg::RegHeight, phase_h[p]);
      set_register(tsnb_pkg::RegFilter, phase_m[p]);
      w = eff_size(width_reg, tsnb_pkg::MaxWidth);
      h = eff_size(height_reg, tsnb_pkg::MaxHeight);
      // Every third phase runs with no idle gaps; phase 4 still drains midway.
      idle_enable = (p % 3) != 1;
      for (n = 0; n < WordsPerPhase; n++) begin
        if (p == 4 && n == WordsPerPhase / 2) drain_samples();
        if ($urandom_range(0, 9) < 3) begin
          // Mostly texels in use; sometimes anywhere in the store.
          if ($urandom_range(0, 3) == 0) write_texel(16'($urandom), $urandom);
          else write_texel(16'($urandom_range(0, w * h - 1)), $urandom);
        end else begin
          sample_at(pick_coord(w), pick_coord(h), 1'b0, rgba_t'(0));
        end
      end
    end

    drain_samples();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== texture_sampler_nearest_bilinear_top.f =====
src/tsnb_pkg.sv
src/texture_sampler_nearest_bilinear_top.sv
src/tsnb_checker.sv
bench/texture_sampler_nearest_bilinear_top_tb.sv
